// ===== hdl/kise_pkg.sv =====
// Package for the inductor steering-error block: widths, register indexes,
// datapath operations and controller status. No dependencies.
`timescale 1ns / 1ps

package kise_pkg;

  localparam int CHANNELS_DEF = 5;
  localparam int ADC_W  = 12;
  localparam int EST_W  = 20;
  localparam int COV_W  = 24;
  localparam int CFG_W  = 16;
  localparam int ERR_W  = 16;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_A  = 3'd0;
  localparam logic [IDX_W-1:0] REG_H  = 3'd1;
  localparam logic [IDX_W-1:0] REG_Q  = 3'd2;
  localparam logic [IDX_W-1:0] REG_R  = 3'd3;
  localparam logic [IDX_W-1:0] REG_WO = 3'd4;
  localparam logic [IDX_W-1:0] REG_WD = 3'd5;
  localparam logic [IDX_W-1:0] REG_WA = 3'd6;
  localparam logic [IDX_W-1:0] REG_P  = 3'd7;

  // Datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,      // latch inputs
    OP_XP,        // t = A*x
    OP_XP_SAT,    // xp = sat(t>>12); t = A*A
    OP_AA,        // aa = t
    OP_PP1,       // t = aa*p (split)
    OP_PP2,       // pp
    OP_HH,        // hh = H*H
    OP_D1,        // t = hh*pp
    OP_D2,        // d = t>>24 + R, num = pp*H
    OP_DIV_START,
    OP_DIV_STEP,
    OP_K,         // k = sat(quo); t = H*xp
    OP_E,         // e
    OP_KE,        // t = k*e
    OP_XN,        // xn; t = k*H
    OP_PN1,       // t = (2^24-kh)*pp
    OP_PN2,       // pn, store, next channel
    OP_ERR1,      // num, den partials
    OP_ERR2,
    OP_ERR3,      // mag = |num| * P
    OP_EDIV_START,
    OP_ERR_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_ch;
  } sts_t;

endpackage

// ===== hdl/kise_ctrl.sv =====
// Controller for the steering-error block: sequences the filter steps per
// channel and the error division. Uses kise_pkg.
`timescale 1ns / 1ps

module kise_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output kise_pkg::cmd_t cmd,
  input  kise_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE, S_XP, S_XPS, S_AA, S_PP1, S_PP2, S_HH, S_D1, S_D2, S_DVS, S_DVW,
    S_K, S_E, S_KE, S_XN, S_PN1, S_PN2, S_ER1, S_ER2, S_ER3, S_EDS, S_EDW,
    S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_stall  = (state_r != S_IDLE) && !(state_r == S_OUT && !out_stall);
  assign out_valid = out_valid_r;

  // Command decode
  always_comb begin
    cmd.op = kise_pkg::OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid) cmd.op = kise_pkg::OP_LOAD;
      S_OUT:  if (!out_stall && in_valid) cmd.op = kise_pkg::OP_LOAD;
      S_XP:   cmd.op = kise_pkg::OP_XP;
      S_XPS:  cmd.op = kise_pkg::OP_XP_SAT;
      S_AA:   cmd.op = kise_pkg::OP_AA;
      S_PP1:  cmd.op = kise_pkg::OP_PP1;
      S_PP2:  cmd.op = kise_pkg::OP_PP2;
      S_HH:   cmd.op = kise_pkg::OP_HH;
      S_D1:   cmd.op = kise_pkg::OP_D1;
      S_D2:   cmd.op = kise_pkg::OP_D2;
      S_DVS:  cmd.op = kise_pkg::OP_DIV_START;
      S_DVW:  cmd.op = kise_pkg::OP_DIV_STEP;
      S_K:    cmd.op = kise_pkg::OP_K;
      S_E:    cmd.op = kise_pkg::OP_E;
      S_KE:   cmd.op = kise_pkg::OP_KE;
      S_XN:   cmd.op = kise_pkg::OP_XN;
      S_PN1:  cmd.op = kise_pkg::OP_PN1;
      S_PN2:  cmd.op = kise_pkg::OP_PN2;
      S_ER1:  cmd.op = kise_pkg::OP_ERR1;
      S_ER2:  cmd.op = kise_pkg::OP_ERR2;
      S_ER3:  cmd.op = kise_pkg::OP_ERR3;
      S_EDS:  cmd.op = kise_pkg::OP_EDIV_START;
      S_EDW:  cmd.op = kise_pkg::OP_DIV_STEP;
      S_FIN:  cmd.op = kise_pkg::OP_ERR_FIN;
      default: cmd.op = kise_pkg::OP_NONE;
    endcase
  end

  // State and registered output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_XP;
        S_XP:   state_r <= S_XPS;
        S_XPS:  state_r <= S_AA;
        S_AA:   state_r <= S_PP1;
        S_PP1:  state_r <= S_PP2;
        S_PP2:  state_r <= S_HH;
        S_HH:   state_r <= S_D1;
        S_D1:   state_r <= S_D2;
        S_D2:   state_r <= S_DVS;
        S_DVS:  state_r <= S_DVW;
        S_DVW:  if (sts.div_done) state_r <= S_K;
        S_K:    state_r <= S_E;
        S_E:    state_r <= S_KE;
        S_KE:   state_r <= S_XN;
        S_XN:   state_r <= S_PN1;
        S_PN1:  state_r <= S_PN2;
        S_PN2:  state_r <= sts.last_ch ? S_ER1 : S_XP;
        S_ER1:  state_r <= S_ER2;
        S_ER2:  state_r <= S_ER3;
        S_ER3:  state_r <= S_EDS;
        S_EDS:  state_r <= S_EDW;
        S_EDW:  if (sts.div_done) state_r <= S_FIN;
        S_FIN: begin
          state_r     <= S_OUT;
          out_valid_r <= 1'b1;
        end
        S_OUT: if (!out_stall) begin
          out_valid_r <= 1'b0;
          state_r     <= in_valid ? S_XP : S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/kise_dp.sv =====
// Datapath for the steering-error block: configuration registers, channel
// state, multiply steps under controller command and a radix-2 divider.
// Uses kise_pkg.
`timescale 1ns / 1ps

module kise_dp #(
  parameter int CHANNELS = kise_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_write,
  input  logic [kise_pkg::IDX_W-1:0]   cfg_index,
  input  logic [kise_pkg::CFG_W-1:0]   cfg_data,
  input  logic [kise_pkg::ADC_W-1:0]   adc [CHANNELS],
  output logic [kise_pkg::EST_W-1:0]   filt [CHANNELS],
  output logic signed [kise_pkg::ERR_W-1:0] steer_error,
  output logic                         divide_fault,
  input  kise_pkg::cmd_t               cmd,
  output kise_pkg::sts_t               sts
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EST_W  = kise_pkg::EST_W;
  localparam int COV_W  = kise_pkg::COV_W;
  localparam int DIV_W  = 64;
  localparam int CNT_W  = 7;
  localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};
  localparam logic [COV_W-1:0] COV_MAX = {COV_W{1'b1}};

  logic [15:0] a_r, h_r, q_r, r_r, wo_r, wd_r, wa_r, p_r;
  logic [EST_W-1:0] est_r [CHANNELS];
  logic [COV_W-1:0] cov_r [CHANNELS];
  logic [kise_pkg::ADC_W-1:0] z_r [CHANNELS];
  logic [CH_W-1:0] ch_r;

  logic [63:0] t_r;           // product register
  logic [31:0] aa_r, hh_r;
  logic [EST_W-1:0] xp_r;
  logic [COV_W-1:0] pp_r;
  logic [15:0] k_r;
  logic signed [33:0] e_r;
  logic signed [47:0] num_r;
  logic [47:0] den_r;
  logic num_neg_r;

  // divider
  logic [DIV_W-1:0] dq_r, drem_r, dden_r;
  logic [CNT_W-1:0] dcnt_r;

  logic [EST_W-1:0] x_c;
  logic [COV_W-1:0] p_c;
  assign x_c = est_r[ch_r];
  assign p_c = cov_r[ch_r];

  assign sts.div_done = (dcnt_r == '0);
  assign sts.last_ch  = (ch_r == CH_W'(CHANNELS - 1));

  logic [DIV_W:0] rem_sh;
  assign rem_sh = {drem_r, dq_r[DIV_W-1]};

  logic signed [47:0] ke_fl;
  logic signed [48:0] xn_s;
  logic [24:0] one_m_kh;
  logic signed [20:0] dlr, dm;
  logic [20:0] adm;
  assign ke_fl = $signed(t_r[59:12]);
  assign xn_s  = $signed({29'd0, xp_r}) + 49'(ke_fl);
  assign one_m_kh = 25'h1000000 - 25'(t_r[31:0]);
  assign dlr = $signed({1'b0, est_r[0]}) - $signed({1'b0, est_r[CHANNELS-1]});
  assign dm  = $signed({1'b0, est_r[1]}) - $signed({1'b0, est_r[CHANNELS-2]});
  assign adm = dm[20] ? 21'(-dm) : 21'(dm);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 16'd4096; h_r <= 16'd4096; q_r <= 16'd128; r_r <= 16'd128;
      wo_r <= 16'd4096; wd_r <= 16'd4096; wa_r <= 16'd4096; p_r <= 16'd2048;
      for (int i = 0; i < CHANNELS; i++) begin
        est_r[i] <= '0;
        cov_r[i] <= '0;
      end
      ch_r   <= '0;
      dcnt_r <= '0;
      divide_fault <= 1'b0;
      steer_error  <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          kise_pkg::REG_A:  a_r  <= cfg_data;
          kise_pkg::REG_H:  h_r  <= cfg_data;
          kise_pkg::REG_Q:  q_r  <= cfg_data;
          kise_pkg::REG_R:  r_r  <= cfg_data;
          kise_pkg::REG_WO: wo_r <= cfg_data;
          kise_pkg::REG_WD: wd_r <= cfg_data;
          kise_pkg::REG_WA: wa_r <= cfg_data;
          kise_pkg::REG_P:  p_r  <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        kise_pkg::OP_LOAD: begin
          z_r  <= adc;
          ch_r <= '0;
        end
        kise_pkg::OP_XP: t_r <= 64'(36'(a_r) * 36'(x_c));
        kise_pkg::OP_XP_SAT: begin
          xp_r <= (t_r[63:12] > 52'(EST_MAX)) ? EST_MAX : t_r[EST_W+11:12];
          t_r  <= 64'(32'(a_r) * 32'(a_r));
        end
        kise_pkg::OP_AA:  aa_r <= t_r[31:0];
        kise_pkg::OP_PP1: t_r  <= 64'(56'(aa_r) * 56'(p_c));
        kise_pkg::OP_PP2: begin
          pp_r <= (({8'd0, t_r[63:24]} + 48'(q_r)) > 48'(COV_MAX)) ? COV_MAX :
                  COV_W'(t_r[63:24] + 40'(q_r));
        end
        kise_pkg::OP_HH: hh_r <= 32'(h_r) * 32'(h_r);
        kise_pkg::OP_D1: t_r  <= 64'(56'(hh_r) * 56'(pp_r));
        kise_pkg::OP_D2: begin
          dden_r <= 64'(t_r[63:24]) + 64'(r_r);
          dq_r   <= 64'(40'(pp_r) * 40'(h_r));
        end
        kise_pkg::OP_DIV_START, kise_pkg::OP_EDIV_START: begin
          drem_r <= '0;
          dcnt_r <= CNT_W'(DIV_W);
          if (cmd.op == kise_pkg::OP_EDIV_START) begin
            dden_r <= 64'(den_r);
            dq_r   <= t_r;
          end
        end
        kise_pkg::OP_DIV_STEP: begin
          if (dcnt_r != '0) begin
            dcnt_r <= dcnt_r - 1'b1;
            if (rem_sh >= {1'b0, dden_r}) begin
              drem_r <= DIV_W'(rem_sh - {1'b0, dden_r});
              dq_r   <= {dq_r[DIV_W-2:0], 1'b1};
            end else begin
              drem_r <= rem_sh[DIV_W-1:0];
              dq_r   <= {dq_r[DIV_W-2:0], 1'b0};
            end
          end
        end
        kise_pkg::OP_K: begin
          // zero divisor leaves the gain at zero
          if (dden_r == '0) k_r <= '0;
          else k_r <= (dq_r > 64'd65535) ? 16'hFFFF : dq_r[15:0];
          t_r <= 64'(36'(h_r) * 36'(xp_r));
        end
        kise_pkg::OP_E:  e_r <= $signed({2'b0, 12'd0, z_r[ch_r], 8'd0}) -
                                $signed({2'b0, t_r[43:12]});
        kise_pkg::OP_KE: t_r <= 64'(51'($signed({1'b0, k_r})) * 51'(e_r));
        kise_pkg::OP_XN: begin
          if (xn_s < 0) est_r[ch_r] <= '0;
          else if (xn_s > 49'(EST_MAX)) est_r[ch_r] <= EST_MAX;
          else est_r[ch_r] <= xn_s[EST_W-1:0];
          t_r <= 64'(32'(k_r) * 32'(h_r));
        end
        kise_pkg::OP_PN1: begin
          if (t_r[31:24] != '0) t_r <= '0;
          else t_r <= 64'(49'(one_m_kh) * 49'(pp_r));
        end
        kise_pkg::OP_PN2: begin
          cov_r[ch_r] <= t_r[47:24];
          if (ch_r != CH_W'(CHANNELS - 1)) ch_r <= ch_r + 1'b1;
        end
        kise_pkg::OP_ERR1: begin
          num_r <= 48'(38'($signed({1'b0, wo_r})) * 38'(dlr));
          den_r <= 48'(37'(wo_r) *
                       37'({1'b0, est_r[0]} + {1'b0, est_r[CHANNELS-1]}));
        end
        kise_pkg::OP_ERR2: begin
          num_r <= num_r + 48'(38'($signed({1'b0, wd_r})) * 38'(dm));
          den_r <= den_r + 48'(37'(wa_r) * 37'(adm));
        end
        kise_pkg::OP_ERR3: begin
          num_neg_r <= num_r[47];
          t_r <= 64'(54'(num_r[47] ? 48'(-num_r) : 48'(num_r)) * 54'(p_r));
        end
        kise_pkg::OP_ERR_FIN: begin
          if (dden_r == '0) begin
            steer_error  <= '0;
            divide_fault <= 1'b1;
          end else begin
            divide_fault <= 1'b0;
            if (num_neg_r)
              steer_error <= (dq_r > 64'd32768) ? 16'sh8000 : 16'(-dq_r[16:0]);
            else
              steer_error <= (dq_r > 64'd32767) ? 16'sh7FFF : 16'(dq_r[15:0]);
          end
        end
        default: ;
      endcase
    end
  end

  assign filt = est_r;

endmodule

// ===== hdl/kalman_inductor_steering_error_top.sv =====
// Five-channel scalar Kalman filter with steering error; one result per
// input transfer. From its input transfer a set passes, per channel, through
// the filter steps on the datapath multipliers and the 64-step radix-2 gain
// division, then through the error sums and the 64-step error division. A new
// set is taken in the cycle the result transfers. Uses kise_pkg, kise_ctrl,
// kise_dp.
`timescale 1ns / 1ps

module kalman_inductor_steering_error_top #(
  parameter int CHANNELS = kise_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_adc_left,
  input  logic [11:0] in_adc_left_mid,
  input  logic [11:0] in_adc_mid,
  input  logic [11:0] in_adc_right_mid,
  input  logic [11:0] in_adc_right,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_filt_left,
  output logic [19:0] out_filt_left_mid,
  output logic [19:0] out_filt_mid,
  output logic [19:0] out_filt_right_mid,
  output logic [19:0] out_filt_right,
  output logic signed [15:0] out_steer_error,
  output logic        out_divide_fault,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  kise_pkg::cmd_t cmd;
  kise_pkg::sts_t sts;
  logic [11:0] adc [CHANNELS];
  logic [19:0] filt [CHANNELS];

  assign adc[0] = in_adc_left;
  assign adc[1] = in_adc_left_mid;
  assign adc[2] = in_adc_mid;
  assign adc[3] = in_adc_right_mid;
  assign adc[4] = in_adc_right;

  assign out_filt_left      = filt[0];
  assign out_filt_left_mid  = filt[1];
  assign out_filt_mid       = filt[2];
  assign out_filt_right_mid = filt[3];
  assign out_filt_right     = filt[4];

  kise_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  kise_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk, .rst_n, .cfg_write, .cfg_index, .cfg_data, .adc, .filt,
    .steer_error(out_steer_error), .divide_fault(out_divide_fault), .cmd, .sts
  );

endmodule

// ===== hdl/kise_checker.sv =====
// Port-level checks for the steering-error block, bound to the top level.
// Depends on kalman_inductor_steering_error_top ports only.
`timescale 1ns / 1ps

module kise_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [15:0] out_steer_error,
  input logic        out_divide_fault
);

  // a fault always carries a zero error
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_fault |-> out_steer_error == 16'sd0)
    else $error("fault with non-zero error");

  // a pending result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_steer_error))
    else $error("result dropped while stalled");

  // an accepted input leaves the block busy with no result pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("input taken while busy");

endmodule

bind kalman_inductor_steering_error_top kise_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_steer_error, .out_divide_fault
);
